### sv/wsh_pkg.sv
package wsh_pkg;

  localparam int unsigned HDR_BYTES = 44;
  localparam int unsigned HDR_CNT_W = 6;

  // input item kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // result kinds
  localparam logic [1:0] OUT_SAMPLE = 2'd0;
  localparam logic [1:0] OUT_BEGIN  = 2'd1;
  localparam logic [1:0] OUT_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_SIZE   = 2'd2;
  localparam logic [1:0] ST_CANCEL = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_CHANNELS = 2'd0;
  localparam logic [1:0] CFG_RATE     = 2'd1;
  localparam logic [1:0] CFG_BITS     = 2'd2;
  localparam logic [1:0] CFG_MAX_DATA = 2'd3;

  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";

  localparam logic [7:0]  FMT_CHUNK_LEN = 8'd16;
  localparam logic [7:0]  FMT_PCM       = 8'd1;
  localparam logic [7:0]  BLOCK_ALIGN   = 8'd2;
  localparam logic [32:0] RIFF_OVERHEAD = 33'd36;

  localparam logic [5:0] HDR_LAST_POS = 6'(HDR_BYTES - 1);

  typedef struct packed {
    logic [15:0] channels;
    logic [30:0] sample_rate;
    logic [15:0] bits;
    logic [22:0] max_data;
  } cfg_t;

  // header fields captured on the fly, plus the running constant-byte check
  typedef struct packed {
    logic        const_bad;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] bits;
    logic [31:0] riff_size;
    logic [23:0] size_lo;
  } hdr_fields_t;

  typedef struct packed {
    logic       chk;
    logic [7:0] val;
  } hdr_exp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [1:0]  code;
  } result_t;

  // first character of the tag is at the lowest header offset
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = tag[31:24];
      2'd1:    b = tag[23:16];
      2'd2:    b = tag[15:8];
      default: b = tag[7:0];
    endcase
    return b;
  endfunction

  // fixed header bytes; configuration-dependent fields are not checked here
  function automatic hdr_exp_t hdr_expect(input logic [5:0] pos);
    hdr_exp_t e;
    e.chk = 1'b1;
    e.val = 8'd0;
    case (pos) inside
      [6'd0:6'd3]:   e.val = tag_byte(TAG_RIFF, pos[1:0]);
      [6'd8:6'd11]:  e.val = tag_byte(TAG_WAVE, pos[1:0]);
      [6'd12:6'd15]: e.val = tag_byte(TAG_FMT, pos[1:0]);
      6'd16:         e.val = FMT_CHUNK_LEN;
      [6'd17:6'd19]: e.val = 8'd0;
      6'd20:         e.val = FMT_PCM;
      6'd21:         e.val = 8'd0;
      6'd32:         e.val = BLOCK_ALIGN;
      6'd33:         e.val = 8'd0;
      [6'd36:6'd39]: e.val = tag_byte(TAG_DATA, pos[1:0]);
      default:       e.chk = 1'b0;
    endcase
    return e;
  endfunction

endpackage

### sv/wsh_hdr_check.sv
module wsh_hdr_check
  import wsh_pkg::*;
(
  input  hdr_fields_t fields,
  input  logic [7:0]  last_byte,
  input  cfg_t        cfg,
  output logic        hdr_ok,
  output logic [22:0] chunk_bytes
);

  logic [31:0] size;
  logic        fmt_ok;
  logic        size_ok;

  assign size = {last_byte, fields.size_lo};

  assign fmt_ok = !fields.const_bad
               && fields.channels == cfg.channels
               && fields.sample_rate == {1'b0, cfg.sample_rate}
               && fields.byte_rate == {cfg.sample_rate, 1'b0}
               && fields.bits == cfg.bits;

  assign size_ok = size != 32'd0 && !size[0]
                && size <= {9'd0, cfg.max_data}
                && {1'b0, fields.riff_size} == {1'b0, size} + RIFF_OVERHEAD;

  assign hdr_ok      = fmt_ok && size_ok;
  // only meaningful when hdr_ok, which bounds size to max_data
  assign chunk_bytes = size[22:0];

endmodule

### sv/wsh_out_buf.sv
module wsh_out_buf
  import wsh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  result_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign has_room  = cnt_r != 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/wav_stream_header_check_pcm_pack.sv
// Path: an input transaction passes the input register, then a 2-entry result buffer.
// Throughput: one input transaction per cycle while the result buffer has room;
//   header checks are parallel compares on fields captured byte by byte, so the 44th
//   header byte is judged in its own cycle.
// Reset: synchronous active-low rst_n clears the stream state and loads register
//   defaults (1 channel, 16000 Hz, 16 bits, 4 MiB data limit).
module wav_stream_header_check_pcm_pack
  import wsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] sample_word, [17:16] status_code, zero pad
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  // ---------------------------------------------------------------
  // Configuration registers; writes are always taken.
  // ---------------------------------------------------------------
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channels    <= 16'd1;
      cfg_r.sample_rate <= 31'd16000;
      cfg_r.bits        <= 16'd16;
      cfg_r.max_data    <= 23'd4194304;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNELS: cfg_r.channels    <= cfg_data[15:0];
        CFG_RATE:     cfg_r.sample_rate <= cfg_data;
        CFG_BITS:     cfg_r.bits        <= cfg_data[15:0];
        CFG_MAX_DATA: cfg_r.max_data    <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Input register. It drains whenever the result buffer has room,
  // so a new transaction can land every cycle.
  // ---------------------------------------------------------------
  logic       in_v_r;
  logic [1:0] in_kind_r;
  logic [7:0] in_byte_r;
  logic       buf_room;
  logic       go;

  assign go        = in_v_r && buf_room;
  assign in_tready = !in_v_r || buf_room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  // ---------------------------------------------------------------
  // Stream state
  // ---------------------------------------------------------------
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic                 hdr_done_r, hdr_done_nxt;
  logic                 const_bad_r, const_bad_nxt;
  logic [22:0]          dsize_r, dsize_nxt;
  logic [22:0]          taken_r, taken_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic                 err_r, err_nxt;
  logic [1:0]           err_code_r, err_code_nxt;

  // captured header fields (payload, no reset)
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] riff_r, riff_nxt;
  logic [23:0] size_lo_r, size_lo_nxt;

  hdr_exp_t    exp_byte;
  hdr_fields_t fields;
  logic        hdr_ok;
  logic [22:0] hdr_size;
  logic        res_v;
  result_t     res;

  assign exp_byte = hdr_expect(hdr_cnt_r);

  // the constant check uses the registered flag only; the last header
  // position has no fixed byte, so it still sees every earlier mismatch
  assign fields.const_bad   = const_bad_r;
  assign fields.channels    = chan_r;
  assign fields.sample_rate = rate_r;
  assign fields.byte_rate   = brate_r;
  assign fields.bits        = bits_r;
  assign fields.riff_size   = riff_r;
  assign fields.size_lo     = size_lo_r;

  wsh_hdr_check u_hdr_check (
    .fields      (fields),
    .last_byte   (in_byte_r),
    .cfg         (cfg_r),
    .hdr_ok      (hdr_ok),
    .chunk_bytes (hdr_size)
  );

  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_done_nxt  = hdr_done_r;
    const_bad_nxt = const_bad_r;
    dsize_nxt     = dsize_r;
    taken_nxt     = taken_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    err_nxt       = err_r;
    err_code_nxt  = err_code_r;
    chan_nxt      = chan_r;
    rate_nxt      = rate_r;
    brate_nxt     = brate_r;
    bits_nxt      = bits_r;
    riff_nxt      = riff_r;
    size_lo_nxt   = size_lo_r;
    res_v         = 1'b0;
    res           = '0;

    if (go) begin
      case (in_kind_r)
        KIND_END: begin
          res_v    = 1'b1;
          res.kind = OUT_STATUS;
          if (err_r) begin
            res.code = err_code_r;
          end else if (!hdr_done_r) begin
            res.code = ST_HEADER;
          end else if (taken_r != dsize_r || pend_v_r) begin
            res.code = ST_SIZE;
          end else begin
            res.code = ST_OK;
          end
          hdr_cnt_nxt   = '0;
          hdr_done_nxt  = 1'b0;
          const_bad_nxt = 1'b0;
          dsize_nxt     = '0;
          taken_nxt     = '0;
          pend_nxt      = '0;
          pend_v_nxt    = 1'b0;
          err_nxt       = 1'b0;
          err_code_nxt  = ST_OK;
        end
        KIND_CANCEL: begin
          if (!err_r) begin
            err_nxt      = 1'b1;
            err_code_nxt = ST_CANCEL;
            res_v        = 1'b1;
            res.kind     = OUT_STATUS;
            res.code     = ST_CANCEL;
          end
        end
        KIND_DATA: begin
          if (!err_r && !hdr_done_r) begin
            hdr_cnt_nxt = hdr_cnt_r + 1'b1;
            if (exp_byte.chk && in_byte_r != exp_byte.val) begin
              const_bad_nxt = 1'b1;
            end
            case (hdr_cnt_r) inside
              [6'd4:6'd7]:   riff_nxt[8*hdr_cnt_r[1:0] +: 8]  = in_byte_r;
              [6'd22:6'd23]: chan_nxt[8*hdr_cnt_r[0] +: 8]    = in_byte_r;
              [6'd24:6'd27]: rate_nxt[8*hdr_cnt_r[1:0] +: 8]  = in_byte_r;
              [6'd28:6'd31]: brate_nxt[8*hdr_cnt_r[1:0] +: 8] = in_byte_r;
              [6'd34:6'd35]: bits_nxt[8*hdr_cnt_r[0] +: 8]    = in_byte_r;
              [6'd40:6'd42]: size_lo_nxt[8*hdr_cnt_r[1:0] +: 8] = in_byte_r;
              default: ;
            endcase
            if (hdr_cnt_r == HDR_LAST_POS) begin
              res_v    = 1'b1;
              if (hdr_ok) begin
                hdr_done_nxt = 1'b1;
                dsize_nxt    = hdr_size;
                res.kind     = OUT_BEGIN;
              end else begin
                err_nxt      = 1'b1;
                err_code_nxt = ST_HEADER;
                res.kind     = OUT_STATUS;
                res.code     = ST_HEADER;
              end
            end
          end else if (!err_r) begin
            if (taken_r >= dsize_r) begin
              // byte beyond the declared data size
              err_nxt      = 1'b1;
              err_code_nxt = ST_SIZE;
              res_v        = 1'b1;
              res.kind     = OUT_STATUS;
              res.code     = ST_SIZE;
            end else begin
              taken_nxt = taken_r + 23'd1;
              if (pend_v_r) begin
                pend_v_nxt = 1'b0;
                res_v      = 1'b1;
                res.kind   = OUT_SAMPLE;
                res.word   = {in_byte_r, pend_r};
              end else begin
                pend_nxt   = in_byte_r;
                pend_v_nxt = 1'b1;
              end
            end
          end
        end
        default: ;  // unused kind, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      hdr_done_r  <= 1'b0;
      const_bad_r <= 1'b0;
      dsize_r     <= '0;
      taken_r     <= '0;
      pend_r      <= '0;
      pend_v_r    <= 1'b0;
      err_r       <= 1'b0;
      err_code_r  <= ST_OK;
    end else begin
      hdr_cnt_r   <= hdr_cnt_nxt;
      hdr_done_r  <= hdr_done_nxt;
      const_bad_r <= const_bad_nxt;
      dsize_r     <= dsize_nxt;
      taken_r     <= taken_nxt;
      pend_r      <= pend_nxt;
      pend_v_r    <= pend_v_nxt;
      err_r       <= err_nxt;
      err_code_r  <= err_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r    <= chan_nxt;
    rate_r    <= rate_nxt;
    brate_r   <= brate_nxt;
    bits_r    <= bits_nxt;
    riff_r    <= riff_nxt;
    size_lo_r <= size_lo_nxt;
  end

  // ---------------------------------------------------------------
  // Result buffer: two entries so a waiting result does not stall input.
  // ---------------------------------------------------------------
  result_t out_res;

  wsh_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_v),
    .push_data (res),
    .has_room  (buf_room),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .out_ready (out_tready)
  );

  assign out_tdata = {6'd0, out_res.code, out_res.word};
  assign out_tuser = out_res.kind;

endmodule

### sv/wsh_checker.sv
module wsh_checker
  import wsh_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // result kind is never the unused code
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == OUT_SAMPLE || out_tuser == OUT_BEGIN
                   || out_tuser == OUT_STATUS)
    else $error("bad result kind");

  // samples carry no status, non-sample results carry no sample word, pad bits are zero
  a_field_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == OUT_SAMPLE ? out_tdata[17:16] == ST_OK
                                            : out_tdata[15:0] == 16'd0)
                   && out_tdata[23:18] == 6'd0)
    else $error("unused result field not zero");

  // stream-begin is never followed directly by another stream-begin
  a_begin_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == OUT_BEGIN
      |=> !(out_tvalid && out_tuser == OUT_BEGIN))
    else $error("repeated stream begin");

endmodule

bind wav_stream_header_check_pcm_pack wsh_checker u_wsh_checker (.*);
